### rtl/frame_rate_meter_limiter_top_defines.svh
// ----------------------------------------------------------------------------
// Frame rate meter / limiter: assertion macros
// Shared property shorthands for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FRAME_RATE_METER_LIMITER_TOP_DEFINES_SVH
`define FRAME_RATE_METER_LIMITER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define FRML_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define FRML_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/frml_pkg.sv
// ----------------------------------------------------------------------------
// Frame rate meter / limiter package
// Field widths, fixed constants and the record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package frml_pkg;

   // Field widths
   localparam int unsigned TS_W    = 32;
   localparam int unsigned FT_W    = 16;
   localparam int unsigned FPS_W   = 22;
   localparam int unsigned DELAY_W = 10;
   localparam int unsigned CAP_W   = 10;

   // Window and queue sizing
   localparam int unsigned WINDOW_SIZE_DEF = 10;
   localparam int unsigned QUEUE_DEPTH     = 2;

   // Arithmetic constants
   localparam int unsigned FT_SAT         = 65535;
   localparam int unsigned FPS_MAX        = 4194303;
   localparam int unsigned FPS_DEFAULT_Q8 = 15360;
   localparam int unsigned FPS_SCALE      = 256000;
   localparam int unsigned FPS_SCALE_W    = $clog2(FPS_SCALE + 1);
   localparam int unsigned MS_PER_S       = 1000;
   localparam int unsigned MAX_FPS_RESET  = 60;
   localparam int unsigned ELAPSED_SAT    = (1 << CAP_W) - 1;

   // One classified frame, front to back
   typedef struct packed {
      logic [FT_W-1:0]  frame_time;
      logic [CAP_W-1:0] elapsed;
   } frame_rec_type;

endpackage

`default_nettype wire

### rtl/frame_rate_meter_limiter_top.sv
// ----------------------------------------------------------------------------
// Frame rate meter / limiter
// Usage:
//   req channel: one beat per finished frame (start and end timestamps, ms).
//   rsp channel: one beat per frame with the frame time, the moving-average
//   rate in Q8 over the last WINDOW_SIZE frames, and the delay to keep the
//   rate under the cap. csr_wr_en/csr_wr_data write the cap (0 = no cap).
//   The rate dividend width NUM_W is 22 bits for a window of 10. The shared
//   bit-serial divider in the back end runs up to twice per frame, for the
//   rate and then the budget, and the back end takes no new frame until
//   it has handed off the last one.
//   A two-entry queue holds accepted frames while the back end works, so
//   req stays ready until the queue is full.
//   Reset clears timestamps, window and queue and sets the cap to 60 fps;
//   the first frame after reset has a frame time of 0.
//   When rsp is stalled the result is held, the back end waits with the
//   next result, and req backs up once the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_rate_meter_limiter_top_defines.svh"

module frame_rate_meter_limiter_top
   import frml_pkg::*;
#(
   parameter int unsigned WINDOW_SIZE = WINDOW_SIZE_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [CAP_W-1:0]   csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [TS_W-1:0]    req_frame_start_ms,
   input  wire logic [TS_W-1:0]    req_frame_end_ms,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [FT_W-1:0]    rsp_frame_time_ms,
   output logic      [FPS_W-1:0]   rsp_fps_q8,
   output logic      [DELAY_W-1:0] rsp_delay_ms
);

   localparam int unsigned REC_W = $bits(frame_rec_type);

   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   frame_rec_type push_rec;
   frame_rec_type pop_rec;

   frml_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_frame_start_ms (req_frame_start_ms),
      .req_frame_end_ms   (req_frame_end_ms),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_rec              (push_rec)
   );

   frml_queue #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_rec),
      .pop       (q_pop),
      .pop_data  (pop_rec),
      .full      (q_full),
      .empty     (q_empty)
   );

   frml_back #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .q_empty           (q_empty),
      .q_rec             (pop_rec),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_time_ms (rsp_frame_time_ms),
      .rsp_fps_q8        (rsp_fps_q8),
      .rsp_delay_ms      (rsp_delay_ms)
   );

   // Checks
   `FRML_ASSERT_NOW(a_no_push_full, q_push, !q_full, "push into full queue")
   `FRML_ASSERT_NOW(a_no_pop_empty, q_pop, !q_empty, "pop from empty queue")
   `FRML_ASSERT_NEXT(a_accept_queued, req_valid && req_ready, !q_empty, "accepted frame lost")
   `FRML_ASSERT_NOW(a_delay_range, rsp_valid, rsp_delay_ms <= DELAY_W'(MS_PER_S), "delay too big")

endmodule

`default_nettype wire

### rtl/frml_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module frml_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 10,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/frml_queue.sv
// ----------------------------------------------------------------------------
// Frame rate meter / limiter queue
// Small register FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module frml_queue #(
   parameter int unsigned WIDTH = 26,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  full,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

`default_nettype wire

### rtl/frml_front.sv
// ----------------------------------------------------------------------------
// Frame rate meter / limiter front
// Accepts frames, derives the frame time and elapsed time, queues a record.
// ----------------------------------------------------------------------------
`default_nettype none

module frml_front
   import frml_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [TS_W-1:0] req_frame_start_ms,
   input  wire logic [TS_W-1:0] req_frame_end_ms,
   input  wire logic            q_full,
   output logic                 q_push,
   output frame_rec_type        q_rec
);

   logic [TS_W-1:0] last_end_ff;
   logic            seen_first_ff;
   logic [TS_W-1:0] delta;
   logic [TS_W-1:0] elapsed;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // Classify: saturate the frame time, clip the elapsed time past any budget
   assign delta   = req_frame_end_ms - last_end_ff;
   assign elapsed = req_frame_end_ms - req_frame_start_ms;

   always_comb begin
      if (!seen_first_ff) begin
         q_rec.frame_time = '0;
      end else if (delta > TS_W'(FT_SAT)) begin
         q_rec.frame_time = FT_W'(FT_SAT);
      end else begin
         q_rec.frame_time = delta[FT_W-1:0];
      end
      if (elapsed > TS_W'(ELAPSED_SAT)) begin
         q_rec.elapsed = CAP_W'(ELAPSED_SAT);
      end else begin
         q_rec.elapsed = elapsed[CAP_W-1:0];
      end
   end

   // Remember the previous frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         last_end_ff   <= '0;
         seen_first_ff <= 1'b0;
      end else if (q_push) begin
         last_end_ff   <= req_frame_end_ms;
         seen_first_ff <= 1'b1;
      end
   end

endmodule

`default_nettype wire

### rtl/frml_div.sv
// ----------------------------------------------------------------------------
// Frame rate meter / limiter divider
// Restoring divider, one quotient bit per cycle, shared by rate and budget.
// ----------------------------------------------------------------------------
`default_nettype none

module frml_div #(
   parameter int unsigned NUM_W = 22,
   parameter int unsigned DEN_W = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic      [NUM_W-1:0] quot
);

   localparam int unsigned IT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quot_ff;
   logic [IT_W-1:0]  iter_ff;
   logic             run_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // One restoring step
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            iter_ff <= IT_W'(NUM_W);
         end else if (run_ff) begin
            iter_ff <= iter_ff - 1'b1;
            if (iter_ff == IT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= numer;
         den_ff  <= denom;
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (run_ff) begin
         num_ff  <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quot_ff <= {quot_ff[NUM_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

### rtl/frml_back.sv
// ----------------------------------------------------------------------------
// Frame rate meter / limiter back
// Updates the frame time window, divides out rate and budget, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module frml_back
   import frml_pkg::*;
#(
   parameter int unsigned WINDOW_SIZE = WINDOW_SIZE_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [CAP_W-1:0]   csr_wr_data,
   input  wire logic               q_empty,
   input  wire frame_rec_type      q_rec,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [FT_W-1:0]    rsp_frame_time_ms,
   output logic      [FPS_W-1:0]   rsp_fps_q8,
   output logic      [DELAY_W-1:0] rsp_delay_ms
);

   localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1);
   localparam int unsigned PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int unsigned SUM_W = FT_W + CNT_W;
   localparam int unsigned NUM_W = (FPS_SCALE_W + CNT_W > FPS_W) ?
                                   (FPS_SCALE_W + CNT_W) : FPS_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_FPS,
      ST_FPS_WAIT,
      ST_CAP,
      ST_CAP_WAIT,
      ST_OUT
   } state_type;

   state_type          state_ff;
   logic [CAP_W-1:0]   max_fps_ff;
   logic [PTR_W-1:0]   ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [SUM_W-1:0]   sum_ff;
   frame_rec_type      rec_ff;
   logic [FPS_W-1:0]   fps_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic               rsp_valid_ff;
   logic [FT_W-1:0]    rsp_ft_ff;
   logic [FPS_W-1:0]   rsp_fps_ff;
   logic [DELAY_W-1:0] rsp_delay_ff;

   logic               full;
   logic [FT_W-1:0]    ring_rd_data;
   logic [FT_W-1:0]    evicted;
   logic               ring_wr;
   logic               div_start;
   logic [NUM_W-1:0]   div_numer;
   logic [SUM_W-1:0]   div_denom;
   logic               div_done;
   logic [NUM_W-1:0]   div_quot;
   logic [CAP_W-1:0]   budget;
   logic               out_free;

   // Frame rate cap register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_fps_ff <= CAP_W'(MAX_FPS_RESET);
      end else if (csr_wr_en) begin
         max_fps_ff <= csr_wr_data;
      end
   end

   assign full     = (count_ff == CNT_W'(WINDOW_SIZE));
   assign evicted  = full ? ring_rd_data : '0;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign ring_wr  = (state_ff == ST_UPDATE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign budget   = div_quot[CAP_W-1:0];

   // Start the divider for the rate when the window sum is nonzero, or for the budget when the cap is on
   assign div_start = ((state_ff == ST_FPS) && (sum_ff != '0)) ||
                      ((state_ff == ST_CAP) && (max_fps_ff != '0));
   assign div_numer = (state_ff == ST_FPS) ?
                      NUM_W'(FPS_SCALE) * NUM_W'(count_ff) : NUM_W'(MS_PER_S);
   assign div_denom = (state_ff == ST_FPS) ? sum_ff : SUM_W'(max_fps_ff);

   frml_ram #(
      .WIDTH (FT_W),
      .DEPTH (WINDOW_SIZE)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (ptr_ff),
      .wr_data (rec_ff.frame_time),
      .rd_en   (q_pop),
      .rd_addr (ptr_ff),
      .rd_data (ring_rd_data)
   );

   frml_div #(
      .NUM_W (NUM_W),
      .DEN_W (SUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Sequence one frame: window update, rate divide, budget divide, hand off
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  rec_ff   <= q_rec;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               sum_ff   <= sum_ff - SUM_W'(evicted) + SUM_W'(rec_ff.frame_time);
               ptr_ff   <= (ptr_ff == PTR_W'(WINDOW_SIZE - 1)) ? '0 : ptr_ff + 1'b1;
               if (!full) begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= ST_FPS;
            end
            ST_FPS: begin
               if (sum_ff == '0) begin
                  fps_ff   <= FPS_W'(FPS_DEFAULT_Q8);
                  state_ff <= ST_CAP;
               end else begin
                  state_ff <= ST_FPS_WAIT;
               end
            end
            ST_FPS_WAIT: begin
               if (div_done) begin
                  fps_ff   <= (div_quot > NUM_W'(FPS_MAX)) ?
                              FPS_W'(FPS_MAX) : div_quot[FPS_W-1:0];
                  state_ff <= ST_CAP;
               end
            end
            ST_CAP: begin
               if (max_fps_ff == '0) begin
                  delay_ff <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_CAP_WAIT;
               end
            end
            ST_CAP_WAIT: begin
               if (div_done) begin
                  delay_ff <= (budget > rec_ff.elapsed) ?
                              DELAY_W'(budget - rec_ff.elapsed) : '0;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ft_ff    <= rec_ff.frame_time;
                  rsp_fps_ff   <= fps_ff;
                  rsp_delay_ff <= delay_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_time_ms = rsp_ft_ff;
   assign rsp_fps_q8        = rsp_fps_ff;
   assign rsp_delay_ms      = rsp_delay_ff;

endmodule

`default_nettype wire

### dv/frame_rate_meter_limiter_checker.sv
// ----------------------------------------------------------------------------
// Frame rate meter / limiter: channel checker
// Watches the cap writes and both channels. Each accepted frame is run through
// a local meter (frame time, windowed Q8 rate, cap delay), and each response
// beat is compared field by field with the oldest pending report.
// ----------------------------------------------------------------------------
module frame_rate_meter_limiter_checker
   import frml_pkg::*;
#(
   parameter int unsigned WINDOW_SIZE = WINDOW_SIZE_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [CAP_W-1:0]   csr_wr_data,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [TS_W-1:0]    req_frame_start_ms,
   input  wire logic [TS_W-1:0]    req_frame_end_ms,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [FT_W-1:0]    rsp_frame_time_ms,
   input  wire logic [FPS_W-1:0]   rsp_fps_q8,
   input  wire logic [DELAY_W-1:0] rsp_delay_ms,
   output int unsigned             frames_pending,
   output int unsigned             mismatch_count
);

   typedef struct packed {
      logic [FT_W-1:0]    frame_time;
      logic [FPS_W-1:0]   fps_q8;
      logic [DELAY_W-1:0] delay_ms;
   } frame_report_type;

   frame_report_type meter_reports[$];

   // Local copy of the meter state and the cap
   logic [CAP_W-1:0] cap_fps;
   logic [TS_W-1:0]  prev_end_ms;
   logic             have_prev;
   logic [FT_W-1:0]  ft_window[WINDOW_SIZE];
   int unsigned      win_idx;
   int unsigned      win_fill;
   int unsigned      win_sum;

   int unsigned      frames_in;
   int unsigned      reports_out;
   int unsigned      miss_count;

   assign frames_pending = frames_in - reports_out;
   assign mismatch_count = miss_count;

   // Advance the meter by one frame and build its report
   function automatic frame_report_type meter_frame(input logic [TS_W-1:0] t_start,
                                                    input logic [TS_W-1:0] t_end);
      frame_report_type rep;
      logic [TS_W-1:0]  since_prev;
      logic [TS_W-1:0]  elapsed;
      logic [63:0]      rate;
      logic [63:0]      budget;
      rep = '0;
      // first frame after reset keeps a frame time of zero
      if (have_prev) begin
         since_prev     = t_end - prev_end_ms;
         rep.frame_time = (since_prev > FT_SAT) ? FT_W'(FT_SAT) : since_prev[FT_W-1:0];
      end
      have_prev   = 1'b1;
      prev_end_ms = t_end;

      // drop the oldest sample once the window is full
      if (win_fill >= WINDOW_SIZE)
         win_sum = win_sum - ft_window[win_idx];
      else
         win_fill = win_fill + 1;
      ft_window[win_idx] = rep.frame_time;
      win_sum = win_sum + rep.frame_time;
      win_idx = (win_idx + 1 >= WINDOW_SIZE) ? 0 : win_idx + 1;

      // an all-zero window reads as 60 fps
      if (win_sum == 0) begin
         rate = FPS_DEFAULT_Q8;
      end else begin
         rate = (64'(FPS_SCALE) * 64'(win_fill)) / 64'(win_sum);
         if (rate > FPS_MAX)
            rate = FPS_MAX;
      end
      rep.fps_q8 = rate[FPS_W-1:0];

      // a zero cap disables the limiter
      if (cap_fps != 0) begin
         elapsed = t_end - t_start;
         budget  = MS_PER_S / cap_fps;
         if (budget > 64'(elapsed))
            rep.delay_ms = DELAY_W'(budget - 64'(elapsed));
      end
      return rep;
   endfunction

   // Sample both channels at each edge
   always @(posedge clock) begin : mon
      frame_report_type got;
      frame_report_type want;
      int unsigned      new_misses;
      new_misses = 0;
      if (reset) begin
         cap_fps     = CAP_W'(MAX_FPS_RESET);
         prev_end_ms = '0;
         have_prev   = 1'b0;
         win_idx     = 0;
         win_fill    = 0;
         win_sum     = 0;
         meter_reports.delete();
         frames_in   <= 0;
         reports_out <= 0;
         miss_count  <= 0;
      end else begin
         if (csr_wr_en)
            cap_fps = csr_wr_data;

         // compare the response beat with the oldest report
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_frame_time_ms, rsp_fps_q8, rsp_delay_ms};
            if (meter_reports.size() == 0) begin
               $error("beat with no frame pending: frame_time_ms %0d fps_q8 %0d delay_ms %0d",
                      got.frame_time, got.fps_q8, got.delay_ms);
               new_misses++;
            end else begin
               want = meter_reports.pop_front();
               if (got.frame_time !== want.frame_time) begin
                  $error("frame_time_ms mismatch: expected %0d, actual %0d",
                         want.frame_time, got.frame_time);
                  new_misses++;
               end
               if (got.fps_q8 !== want.fps_q8) begin
                  $error("fps_q8 mismatch: expected %0d, actual %0d",
                         want.fps_q8, got.fps_q8);
                  new_misses++;
               end
               if (got.delay_ms !== want.delay_ms) begin
                  $error("delay_ms mismatch: expected %0d, actual %0d",
                         want.delay_ms, got.delay_ms);
                  new_misses++;
               end
               reports_out <= reports_out + 1;
            end
         end

         // predict the report of each accepted frame
         if (req_valid && req_ready) begin
            meter_reports.push_back(meter_frame(req_frame_start_ms, req_frame_end_ms));
            frames_in <= frames_in + 1;
         end

         miss_count <= miss_count + new_misses;
      end
   end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// Frame rate meter / limiter: testbench top
// Drives frames in random bursts under a stalling receiver, walks the cap
// through zero, one, the top of its range and beyond, and reports the verdict
// from the mismatch count of the channel checker.
// ----------------------------------------------------------------------------
module tb;
   import frml_pkg::*;

   // The slowest correct run has about 1525 frames, each with the longest sender
   // gap and a stalled response, and still ends well under CYCLE_LIMIT.
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned PHASES        = 6;
   localparam int unsigned PHASE_FRAMES  = 250;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [CAP_W-1:0]   csr_wr_data;
   logic               req_valid;
   logic               req_ready;
   logic [TS_W-1:0]    req_frame_start_ms;
   logic [TS_W-1:0]    req_frame_end_ms;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [FT_W-1:0]    rsp_frame_time_ms;
   logic [FPS_W-1:0]   rsp_fps_q8;
   logic [DELAY_W-1:0] rsp_delay_ms;

   int unsigned        frames_pending;
   int unsigned        mismatch_count;
   int unsigned        cycle_count = 0;
   int unsigned        burst_left = 0;
   logic [TS_W-1:0]    stamp_ms;

   // Receiver pacing state
   logic               hold_rsp = 1'b0;
   logic               hold_done = 1'b0;
   int unsigned        hold_cnt = 0;
   int unsigned        mode_left = 0;
   int unsigned        stall_pct = 0;

   frame_rate_meter_limiter_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_frame_start_ms (req_frame_start_ms),
      .req_frame_end_ms   (req_frame_end_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_time_ms  (rsp_frame_time_ms),
      .rsp_fps_q8         (rsp_fps_q8),
      .rsp_delay_ms       (rsp_delay_ms)
   );

   frame_rate_meter_limiter_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_frame_start_ms (req_frame_start_ms),
      .req_frame_end_ms   (req_frame_end_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_time_ms  (rsp_frame_time_ms),
      .rsp_fps_q8         (rsp_fps_q8),
      .rsp_delay_ms       (rsp_delay_ms),
      .frames_pending     (frames_pending),
      .mismatch_count     (mismatch_count)
   );

   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stall the response channel: random modes, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= 0;
         hold_done <= 1'b0;
         mode_left <= 0;
         stall_pct <= 0;
      end else if (hold_cnt != 0) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= hold_cnt - 1;
      end else if (hold_rsp && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            mode_left <= $urandom_range(16, 200);
            case ($urandom_range(0, 3))
               0: begin
                  stall_pct <= 0;
               end
               1: begin
                  stall_pct <= 25;
               end
               2: begin
                  stall_pct <= 50;
               end
               default: begin
                  stall_pct <= 85;
               end
            endcase
         end else begin
            mode_left <= mode_left - 1;
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Offer one frame, hold it until accepted, then pace the next burst
   task automatic send_frame(input logic [TS_W-1:0] t_start, input logic [TS_W-1:0] t_end);
      int unsigned gap;
      req_valid          <= 1'b1;
      req_frame_start_ms <= t_start;
      req_frame_end_ms   <= t_end;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      stamp_ms = t_end;
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering and wait until every frame has its response
   task automatic drain_reports;
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0)
         @(posedge clock);
   endtask

   // Write the cap while the block is idle
   task automatic write_cap(input logic [CAP_W-1:0] cap);
      drain_reports();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Build a random frame: mostly steady frame rates, some jumps and noise
   task automatic random_frame();
      logic [TS_W-1:0] t_start;
      logic [TS_W-1:0] t_end;
      case ($urandom_range(0, 19))
         0: begin
            t_start = $urandom;
            t_end   = $urandom;
         end
         1: begin
            t_end   = stamp_ms + $urandom_range(65536, 400000);
            t_start = t_end - $urandom_range(0, 30);
         end
         2, 3: begin
            t_end   = stamp_ms;
            t_start = t_end - $urandom_range(0, 2);
         end
         4: begin
            t_end   = stamp_ms + $urandom_range(1, 60);
            t_start = $urandom;
         end
         5: begin
            t_end   = stamp_ms + $urandom_range(60, 1200);
            t_start = t_end - $urandom_range(0, 1200);
         end
         default: begin
            t_end   = stamp_ms + $urandom_range(1, 60);
            t_start = t_end - $urandom_range(0, 30);
         end
      endcase
      send_frame(t_start, t_end);
   endtask

   initial begin
      int unsigned phase;
      int unsigned n;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_valid          = 1'b0;
      req_frame_start_ms = '0;
      req_frame_end_ms   = '0;
      stamp_ms           = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // First frame, then an all-zero window at the reset cap
      send_frame(32'd0, 32'd0);
      send_frame(32'd0, 32'd0);
      send_frame(32'd5, 32'd16);
      send_frame(32'd16, 32'd33);
      // end before start
      send_frame(32'd100, 32'd50);
      // saturated frame times
      send_frame(32'd50, 32'h1000_0032);
      send_frame(32'hFFFF_FFEB, 32'hFFFF_FFF0);
      // end timestamp wraps
      send_frame(32'hFFFF_FFF8, 32'h0000_0010);
      send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_frame(32'h0000_0000, 32'hFFFF_FFFF);
      // steady 16 ms frames push the oldest samples out of the window
      for (n = 1; n <= 6; n++)
         send_frame(16 * n - 5, 16 * n - 1);

      // No cap
      write_cap('0);
      send_frame(stamp_ms + 2, stamp_ms + 10);
      send_frame(stamp_ms + 10, stamp_ms + 10);
      // One fps: the whole second is budget
      write_cap(CAP_W'(1));
      send_frame(stamp_ms + 16, stamp_ms + 16);
      send_frame(stamp_ms + 16 - 999, stamp_ms + 16);
      // Top of the range and above it
      write_cap(CAP_W'(1000));
      send_frame(stamp_ms + 16, stamp_ms + 16);
      write_cap('1);
      send_frame(stamp_ms + 16, stamp_ms + 16);

      // Random phases, each under its own cap
      for (phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0: begin
               write_cap('0);
            end
            1: begin
               write_cap(CAP_W'(1));
            end
            2: begin
               write_cap(CAP_W'(1000));
            end
            3: begin
               write_cap('1);
            end
            default: begin
               write_cap(CAP_W'($urandom_range(1, 1000)));
            end
         endcase
         for (n = 0; n < PHASE_FRAMES; n++) begin
            // hold the receiver off while the sender keeps pushing
            if (phase == 1 && n == 40) begin
               hold_rsp   <= 1'b1;
               burst_left = 60;
            end
            random_frame();
         end
      end

      drain_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && frames_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
